/* src/assert_macros.svh */
// Assertion macros for the RTL of the frame text parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, disabled during reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a plain condition holds on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

/* src/frt_pkg.sv */
// Shared types and constants of the replay frame text parser.
package frt_pkg;

   // Characters that steer the parse
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // Overflow bounds: the value may take one more digit only while it stays
   // at or under the quotient, and at the quotient only with a small digit.
   localparam logic [63:0] DELTA_QUOT  = 64'd922337203685477580;
   localparam logic [31:0] KEYS_QUOT   = 32'd214748364;
   localparam logic [3:0]  DIG_REM_POS = 4'd7;
   localparam logic [3:0]  DIG_REM_NEG = 4'd8;

   // Largest running time
   localparam logic [62:0] TIME_MAX = {63{1'b1}};

   // One closed frame handed from the character parser to the time stage
   typedef struct packed {
      logic        err;
      logic [62:0] delta;
      logic [31:0] keys_mag;
      logic        keys_neg;
   } frame_rec_type;

endpackage

/* src/frt_char_parser.sv */
// Character stage: field splitting, decimal parsing and frame close detection.
module frt_char_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [7:0]            in_char,
   input  logic                  in_last,
   output logic                  in_ready,
   output logic                  rec_vld,
   output frt_pkg::frame_rec_type rec,
   input  logic                  rec_take
);
   import frt_pkg::*;

   typedef enum logic [1:0] {
      PH_WS   = 2'd0,
      PH_SIGN = 2'd1,
      PH_DIG  = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0]  fn;
      logic        nonempty;
      logic        second;
      logic [63:0] dval;
      logic        dneg;
      logic        dnz;
      phase_type   dph;
      logic [31:0] kval;
      logic        kneg;
      phase_type   kph;
      logic        err;
   } seg_type;

   typedef struct packed {
      phase_type phase;
      logic      neg;
      logic      acc;
      logic      err;
   } feed_type;

   // Phase step of one number field for one character
   function automatic feed_type feed(input phase_type ph, input logic neg,
                                     input logic [7:0] c);
      feed_type f;
      logic     sp;
      logic     sg;
      logic     dg;
      sp = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
      sg = (c == CH_PLUS) || (c == CH_MINUS);
      dg = c inside {[CH_ZERO:CH_NINE]};
      f.phase = ph;
      f.neg   = neg;
      f.acc   = 1'b0;
      f.err   = 1'b0;
      case (ph)
         PH_WS: begin
            if (sp) begin
               f.phase = PH_WS;
            end else if (sg) begin
               f.neg   = (c == CH_MINUS);
               f.phase = PH_SIGN;
            end else if (dg) begin
               f.phase = PH_DIG;
               f.acc   = 1'b1;
            end else begin
               f.phase = PH_DONE;
               f.err   = 1'b1;
            end
         end
         PH_SIGN: begin
            if (dg) begin
               f.phase = PH_DIG;
               f.acc   = 1'b1;
            end else begin
               f.phase = PH_DONE;
               f.err   = 1'b1;
            end
         end
         PH_DIG: begin
            if (dg) begin
               f.acc = 1'b1;
            end else begin
               f.phase = PH_DONE;
            end
         end
         default: begin
            f.phase = ph;
         end
      endcase
      return f;
   endfunction

   seg_type       seg_ff, seg_in, took;
   seg_type       s;
   frame_rec_type rec_ff, rec_in;
   logic          rec_vld_ff, rec_vld_in;
   feed_type      fd, fk;
   logic [3:0]    digit;
   logic [3:0]    d_rem, k_rem;
   logic          d_ovf, k_ovf;
   logic          is_comma, is_bar, closing, err_c, emit;

   // digits sit at 0x30..0x39, so the low nibble is the digit value
   assign digit    = in_char[3:0];
   assign is_comma = (in_char == CH_COMMA);
   assign is_bar   = (in_char == CH_BAR);

   assign fd = feed(seg_ff.dph, seg_ff.dneg, in_char);
   assign fk = feed(seg_ff.kph, seg_ff.kneg, in_char);

   assign d_rem = seg_ff.dneg ? DIG_REM_NEG : DIG_REM_POS;
   assign k_rem = seg_ff.kneg ? DIG_REM_NEG : DIG_REM_POS;
   assign d_ovf = (seg_ff.dval > DELTA_QUOT) ||
                  ((seg_ff.dval == DELTA_QUOT) && (digit > d_rem));
   assign k_ovf = (seg_ff.kval > KEYS_QUOT) ||
                  ((seg_ff.kval == KEYS_QUOT) && (digit > k_rem));

   // Segment state after taking a non-comma character
   always_comb begin
      took          = seg_ff;
      took.nonempty = 1'b1;
      if (seg_ff.fn != 2'd0) begin
         took.second = 1'b1;
      end
      if (is_bar) begin
         if ((seg_ff.fn == 2'd0) && ((seg_ff.dph == PH_WS) || (seg_ff.dph == PH_SIGN))) begin
            took.err = 1'b1;
         end
         if ((seg_ff.fn == 2'd1) && ((seg_ff.kph == PH_WS) || (seg_ff.kph == PH_SIGN))) begin
            took.err = 1'b1;
         end
         if (seg_ff.fn != 2'd2) begin
            took.fn = seg_ff.fn + 2'd1;
         end
      end else if (seg_ff.fn == 2'd0) begin
         took.dph = fd.phase;
         took.dneg = fd.neg;
         if (fd.err) begin
            took.err = 1'b1;
         end
         if (fd.acc) begin
            if (d_ovf) begin
               took.err = 1'b1;
            end else begin
               took.dval = (seg_ff.dval << 3) + (seg_ff.dval << 1) + {60'd0, digit};
               took.dnz  = seg_ff.dnz || (digit != 4'd0);
            end
         end
      end else if (seg_ff.fn == 2'd1) begin
         took.kph = fk.phase;
         took.kneg = fk.neg;
         if (fk.err) begin
            took.err = 1'b1;
         end
         if (fk.acc) begin
            if (k_ovf) begin
               took.err = 1'b1;
            end else begin
               took.kval = (seg_ff.kval << 3) + (seg_ff.kval << 1) + {28'd0, digit};
            end
         end
      end
   end

   // Frame close: a comma closes the current segment, a last character
   // closes the segment it has just extended
   always_comb begin
      closing = is_comma || in_last;
      s       = is_comma ? seg_ff : took;
      err_c   = s.err || ((s.fn == 2'd1) && ((s.kph == PH_WS) || (s.kph == PH_SIGN)));
      emit    = closing && s.nonempty && s.second && (err_c || !(s.dneg && s.dnz));
      rec_in.err      = err_c;
      rec_in.delta    = s.dval[62:0];
      rec_in.keys_mag = s.kval;
      rec_in.keys_neg = s.kneg;
      seg_in = closing ? '0 : took;
   end

   assign in_ready   = !rec_vld_ff || rec_take;
   assign rec_vld_in = in_accept ? emit : (rec_vld_ff && !rec_take);

   // Segment state and frame record registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff     <= '0;
         rec_vld_ff <= 1'b0;
      end else begin
         rec_vld_ff <= rec_vld_in;
         if (in_accept) begin
            seg_ff <= seg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept && emit) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_vld = rec_vld_ff;
   assign rec     = rec_ff;

endmodule

/* src/frt_time_accum.sv */
// Time stage: saturating running time, keys sign and the result register.
module frt_time_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rec_vld,
   input  frt_pkg::frame_rec_type rec,
   output logic                   rec_take,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_status,
   output logic [62:0]            out_time,
   output logic [31:0]            out_keys
);
   import frt_pkg::*;

   logic [62:0] rt_ff, rt_in;
   logic        out_vld_ff;
   logic        status_ff;
   logic [62:0] time_ff, time_in;
   logic [31:0] keys_ff, keys_in;
   logic [63:0] sum;
   logic        adv;
   logic        load;

   // the result register moves whenever it is empty or being drained
   assign adv      = !out_vld_ff || out_ready;
   assign rec_take = adv;
   assign load     = rec_vld && adv;

   // Add with saturation at the largest time
   assign sum   = {1'b0, rt_ff} + {1'b0, rec.delta};
   assign rt_in = sum[63] ? TIME_MAX : sum[62:0];

   // Error results carry zeros
   assign time_in = rec.err ? 63'd0 : rt_in;
   assign keys_in = rec.err ? 32'd0 :
                    (rec.keys_neg ? (~rec.keys_mag + 32'd1) : rec.keys_mag);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         rt_ff      <= '0;
      end else begin
         if (adv) begin
            out_vld_ff <= rec_vld;
         end
         if (load && !rec.err) begin
            rt_ff <= rt_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= rec.err;
         time_ff   <= time_in;
         keys_ff   <= keys_in;
      end
   end

   assign out_valid  = out_vld_ff;
   assign out_status = status_ff;
   assign out_time   = time_ff;
   assign out_keys   = keys_ff;

endmodule

/* src/replay_frame_text_parser_unit.sv */
// Replay frame text parser: one text character in, at most one frame out.
//
// Input channel req_*: one byte of frame text per item in req_tdata, with
// req_tlast on the final character of the text. Frames are split at commas,
// fields at bars; the first two fields are the time delta and the keys.
// Result channel rsp_*: rsp_tuser is the status (1 = malformed or out of
// range number), rsp_tdata carries the accumulated frame time and the keys.
// A closed frame passes the record register and then the result register.
// Throughput: one character per cycle while req_tready is high; the
// character stage does one digit step per cycle and the time stage one
// 64-bit add per closed frame, so neither holds the stream.
// Characters that close no frame, or a frame that is skipped, give no item.
// Reset (synchronous, active high) clears the running time and the
// partially parsed frame and empties both pipeline registers.
// When the receiver stalls, the result register holds; one more closed
// frame can wait in the record register, after which req_tready drops.
`include "assert_macros.svh"

module replay_frame_text_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_char
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [62:0] frame_time, [94:63] key_state, [95] zero
   output logic        rsp_tuser    // [0] status
);
   import frt_pkg::*;

   frame_rec_type rec;
   logic          rec_vld;
   logic          rec_take;
   logic          req_accept;
   logic [62:0]   frame_time;
   logic [31:0]   key_state;

   assign req_accept = req_tvalid && req_tready;

   // Character stage
   frt_char_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_char   (req_tdata),
      .in_last   (req_tlast),
      .in_ready  (req_tready),
      .rec_vld   (rec_vld),
      .rec       (rec),
      .rec_take  (rec_take)
   );

   // Time stage and result register
   frt_time_accum u_time (
      .clock      (clock),
      .reset      (reset),
      .rec_vld    (rec_vld),
      .rec        (rec),
      .rec_take   (rec_take),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_tuser),
      .out_time   (frame_time),
      .out_keys   (key_state)
   );

   assign rsp_tdata = {1'b0, key_state, frame_time};

   // Checks
   `ASSERT_PROP(a_err_zero, clock, reset, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 96'd0), "error item with nonzero payload")
   `ASSERT_PROP(a_stall_src, clock, reset, !req_tready |-> (rsp_tvalid && !rsp_tready && rec_vld), "input stalled without a full pipeline")
   `ASSERT_ALWAYS(a_pad_zero, clock, reset, !rsp_tvalid || !rsp_tdata[95], "padding bit set")

endmodule
